// ===== src/eoat_pkg.sv =====
package eoat_pkg;

  // Field widths.
  localparam int SMP_W      = 12;
  localparam int PCT_W      = 7;
  localparam int THR_W      = 16;
  localparam int FIXQ_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int AVG_W      = 12;
  localparam int LO_W       = 12;
  localparam int HI_W       = 13;

  // Converter levels and limits.
  localparam logic [SMP_W-1:0] SUPPLY_MIN = 12'd100;
  localparam logic [SMP_W-1:0] BAT_EMPTY  = 12'd2171;
  localparam logic [SMP_W-1:0] BAT_FULL   = 12'd2543;
  localparam logic [THR_W-1:0] THR_NONE   = 16'hFFFF;
  localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;

  // Battery percent: (s - empty) * 100 / 372 by a reciprocal multiply.
  // The scaled numerator stays below 2^16, so a 25 bit shift is exact.
  localparam int unsigned     BAT_SPAN   = 372;
  localparam int              BAT_DIFF_W = 9;
  localparam int              BAT_K      = 25;
  localparam longint unsigned BAT_M      = ((64'd1 << BAT_K) + BAT_SPAN - 1) / BAT_SPAN;
  localparam longint unsigned BAT_MUL    = 100 * BAT_M;
  localparam int              BAT_MUL_W  = 24;

  // Fuel percent: 100 - s * 100 / 4095, numerator below 2^19, 31 bit shift.
  localparam int unsigned     ADC_FULL   = 4095;
  localparam int              FUEL_K     = 31;
  localparam longint unsigned FUEL_M     = ((64'd1 << FUEL_K) + ADC_FULL - 1) / ADC_FULL;
  localparam longint unsigned FUEL_MUL   = 100 * FUEL_M;
  localparam int              FUEL_MUL_W = 26;

  // Threshold candidates: avg * 4 / 5 and avg * 6 / 5.
  localparam int              LO_K     = 17;
  localparam longint unsigned LO_MUL   = 4 * (((64'd1 << LO_K) + 4) / 5);
  localparam int              LO_MUL_W = 17;
  localparam int              HI_K     = 18;
  localparam longint unsigned HI_MUL   = 6 * (((64'd1 << HI_K) + 4) / 5);
  localparam int              HI_MUL_W = 19;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_UNIT_ON     = 3'd0,
    CFG_ON_FOLLOWS_ENGINE = 3'd1,
    CFG_INVERT_KEY        = 3'd2,
    CFG_FORCE_DOOR_OPEN   = 3'd3,
    CFG_INVERT_DOOR       = 3'd4,
    CFG_SAVED_THRESHOLD   = 3'd5
  } cfg_reg_e;

  // Window status handed to the decision stage.
  typedef struct packed {
    logic             full;
    logic [AVG_W-1:0] avg;
    logic [LO_W-1:0]  low_thr;
    logic [HI_W-1:0]  high_thr;
  } win_stat_t;

  // A zero saved threshold means no threshold at all.
  function automatic logic [THR_W-1:0] restore_thr(input logic [THR_W-1:0] v);
    return (v == '0) ? THR_NONE : v;
  endfunction

endpackage

// ===== src/eoat_in_if.sv =====
interface eoat_in_if import eoat_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SMP_W-1:0]  battery_sample;
  logic [SMP_W-1:0]  supply_sample;
  logic [SMP_W-1:0]  fuel_sample;
  logic              key_pin;
  logic              door_pin;
  logic              rmc_valid;
  logic              gga_valid;
  logic              gsa_valid;
  logic [FIXQ_W-1:0] fix_quality;
  logic              vehicle_standby;

  modport source (
    output valid, battery_sample, supply_sample, fuel_sample, key_pin, door_pin,
           rmc_valid, gga_valid, gsa_valid, fix_quality, vehicle_standby,
    input  ready
  );
  modport sink (
    input  valid, battery_sample, supply_sample, fuel_sample, key_pin, door_pin,
           rmc_valid, gga_valid, gsa_valid, fix_quality, vehicle_standby,
    output ready
  );
endinterface

// ===== src/eoat_out_if.sv =====
interface eoat_out_if import eoat_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] battery_percent;
  logic             supply_connected;
  logic             engine_running;
  logic             engine_changed;
  logic [PCT_W-1:0] fuel_percent;
  logic             unit_on;
  logic             door_open;
  logic [THR_W-1:0] threshold_value;
  logic             threshold_store;

  modport source (
    output valid, battery_percent, supply_connected, engine_running, engine_changed,
           fuel_percent, unit_on, door_open, threshold_value, threshold_store,
    input  ready
  );
  modport sink (
    input  valid, battery_percent, supply_connected, engine_running, engine_changed,
           fuel_percent, unit_on, door_open, threshold_value, threshold_store,
    output ready
  );
endinterface

// ===== src/eoat_cfg_if.sv =====
interface eoat_cfg_if import eoat_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/eoat_cell.sv =====
module eoat_cell import eoat_pkg::*; (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [SMP_W-1:0] sample_i,
  output logic [SMP_W-1:0] sample_o
);

  logic [SMP_W-1:0] sample_q;

  // Take the neighbor's sample when the window advances.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

// ===== src/eoat_window.sv =====
module eoat_window import eoat_pkg::*; #(
  parameter int WINDOW = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [SMP_W-1:0] sample_i,
  output win_stat_t        stat_o
);

  localparam int              FILL_W = $clog2(WINDOW + 1);
  localparam int              TOT_W  = $clog2(WINDOW * 4095 + 1);
  localparam int              AVG_L  = $clog2(WINDOW);
  localparam int              AVG_K  = TOT_W + AVG_L;
  localparam int              AVG_MW = TOT_W + 1;
  localparam longint unsigned AVG_M  = ((64'd1 << AVG_K) + WINDOW - 1) / WINDOW;
  localparam int              AVG_PW = TOT_W + AVG_MW;
  localparam int              LO_PW  = AVG_W + LO_MUL_W;
  localparam int              HI_PW  = AVG_W + HI_MUL_W;

  logic [SMP_W-1:0]  tap [WINDOW];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [TOT_W-1:0]  total_q, total_d;
  logic              full;
  logic [AVG_PW-1:0] avg_prod;
  logic [AVG_W-1:0]  avg_q, avg2_q;
  logic [LO_PW-1:0]  lo_prod;
  logic [HI_PW-1:0]  hi_prod;
  logic [LO_W-1:0]   lo_q;
  logic [HI_W-1:0]   hi_q;

  // Row of sample cells; the last one holds the oldest sample.
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    if (g == 0) begin : g_head
      eoat_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (push_i),
        .sample_i (sample_i),
        .sample_o (tap[g])
      );
    end else begin : g_body
      eoat_cell u_cell (
        .clk_i    (clk_i),
        .shift_i  (push_i),
        .sample_i (tap[g-1]),
        .sample_o (tap[g])
      );
    end
  end

  assign full = (fill_q == FILL_W'(WINDOW));

  // Running sum and fill count; a full window drops its oldest sample.
  always_comb begin
    total_d = total_q;
    fill_d  = fill_q;
    if (push_i) begin
      total_d = total_q + TOT_W'(sample_i) - (full ? TOT_W'(tap[WINDOW-1]) : '0);
      fill_d  = full ? fill_q : fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  // Average first, then both threshold candidates from the registered average.
  assign avg_prod = AVG_PW'(total_q) * AVG_PW'(AVG_M);
  assign lo_prod  = LO_PW'(avg_q) * LO_PW'(LO_MUL);
  assign hi_prod  = HI_PW'(avg_q) * HI_PW'(HI_MUL);

  always_ff @(posedge clk_i) begin
    avg_q  <= AVG_W'(avg_prod >> AVG_K);
    avg2_q <= avg_q;
    lo_q   <= LO_W'(lo_prod >> LO_K);
    hi_q   <= HI_W'(hi_prod >> HI_K);
  end

  assign stat_o = '{full: full, avg: avg2_q, low_thr: lo_q, high_thr: hi_q};

  // The fill count saturates at the window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FILL_W'(WINDOW))
    else $error("window fill count beyond window length");

  // A push into a full window keeps it full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full |=> fill_q == FILL_W'(WINDOW))
    else $error("full window lost a sample count");

  // The running sum never exceeds a window of full scale samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOT_W'(WINDOW * 4095))
    else $error("window sum out of range");

endmodule

// ===== src/engine_on_adaptive_threshold.sv =====
// Engine-on detector with an adaptive threshold. Each input beat is one sensing
// tick and yields exactly one result beat; a new tick is taken only once the
// decision stage is empty, which lets the window average pipeline (sum, average,
// then the 4/5 and 6/5 candidates) settle before the next threshold decision. A
// result still waiting on the output holds off the next tick, so every decision
// is made in the cycle right after its tick, while the candidates still describe
// the window without the new sample. The last WINDOW connected supply samples sit
// in a shift chain of cells with a running sum; no clearing pass is needed after
// reset. Ticks with a supply below 100 report engine-on and leave the window and
// threshold alone. Configuration is written by the user only while the block is
// idle, which the block does not enforce; writing saved_threshold reloads the
// threshold at once, zero meaning 65535. threshold_store flags each adaptation.
module engine_on_adaptive_threshold import eoat_pkg::*; #(
  parameter int WINDOW = 50
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  eoat_cfg_if.sink   cfg_i,
  eoat_in_if.sink    in_i,
  eoat_out_if.source out_o
);

  localparam int BAT_PW  = BAT_DIFF_W + BAT_MUL_W;
  localparam int FUEL_PW = SMP_W + FUEL_MUL_W;

  win_stat_t stat;

  logic in_fire, s1_fire, cfg_fire, conn_in;

  // Configuration registers.
  logic force_unit_on_q, on_follows_engine_q, invert_key_q;
  logic force_door_open_q, invert_door_q;

  // Threshold state.
  logic [THR_W-1:0] thr_q;
  logic             last_engine_q;

  // Decision stage.
  logic             s1_valid_q;
  logic [SMP_W-1:0] s1_bat_q, s1_sup_q, s1_fuel_q;
  logic             s1_key_q, s1_door_q, s1_good_q, s1_conn_q, s1_adapt_q;

  logic [THR_W-1:0]      thr_new;
  logic                  engine, changed, unit_on, door_open;
  logic [BAT_DIFF_W-1:0] bat_diff;
  logic [BAT_PW-1:0]     bat_prod;
  logic [FUEL_PW-1:0]    fuel_prod;
  logic [PCT_W-1:0]      bat_pct, fuel_pct;

  // Output register.
  logic             out_valid_q;
  logic [PCT_W-1:0] out_bat_q, out_fuel_q;
  logic             out_conn_q, out_engine_q, out_changed_q;
  logic             out_unit_q, out_door_q, out_store_q;
  logic [THR_W-1:0] out_thr_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // A tick is taken when the decision stage is empty and the result register
  // is free by the next edge, so the decision always follows in the next cycle.
  assign in_i.ready = !s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign conn_in    = (in_i.supply_sample >= SUPPLY_MIN);

  eoat_window #(.WINDOW(WINDOW)) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_fire && conn_in),
    .sample_i (in_i.supply_sample),
    .stat_o   (stat)
  );

  // Capture the tick together with the window's full flag before the push.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bat_q   <= in_i.battery_sample;
      s1_sup_q   <= in_i.supply_sample;
      s1_fuel_q  <= in_i.fuel_sample;
      s1_key_q   <= in_i.key_pin;
      s1_door_q  <= in_i.door_pin;
      s1_good_q  <= in_i.rmc_valid && (in_i.gga_valid || in_i.gsa_valid) &&
                    (in_i.fix_quality != '0) && !in_i.vehicle_standby;
      s1_conn_q  <= conn_in;
      s1_adapt_q <= conn_in && stat.full;
    end
  end

  // Threshold adaptation and engine decision.
  always_comb begin
    thr_new = thr_q;
    if (s1_adapt_q) begin
      if (s1_good_q) begin
        thr_new = THR_W'(stat.low_thr);
      end else if (thr_q >= THR_W'(stat.avg)) begin
        thr_new = THR_W'(stat.high_thr);
      end
    end
    engine  = s1_conn_q ? (THR_W'(s1_sup_q) > thr_new) : 1'b1;
    changed = s1_conn_q && (engine != last_engine_q);
  end

  // Battery and fuel percentages.
  assign bat_diff  = BAT_DIFF_W'(s1_bat_q - BAT_EMPTY);
  assign bat_prod  = BAT_PW'(bat_diff) * BAT_PW'(BAT_MUL);
  assign fuel_prod = FUEL_PW'(s1_fuel_q) * FUEL_PW'(FUEL_MUL);

  always_comb begin
    if (s1_bat_q <= BAT_EMPTY) begin
      bat_pct = '0;
    end else if (s1_bat_q >= BAT_FULL) begin
      bat_pct = PCT_FULL;
    end else begin
      bat_pct = PCT_W'(bat_prod >> BAT_K);
    end
    fuel_pct = PCT_FULL - PCT_W'(fuel_prod >> FUEL_K);
  end

  // Unit-on and door mapping.
  always_comb begin
    if (force_unit_on_q) begin
      unit_on = 1'b1;
    end else if (on_follows_engine_q) begin
      unit_on = engine;
    end else begin
      unit_on = !s1_key_q ^ invert_key_q;
    end
    door_open = force_door_open_q ? 1'b1 : (s1_door_q ^ invert_door_q);
  end

  // Threshold and last decision; a restore write reloads the threshold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= THR_NONE;
      last_engine_q <= 1'b0;
    end else if (s1_fire) begin
      thr_q <= thr_new;
      if (s1_conn_q) begin
        last_engine_q <= engine;
      end
    end else if (cfg_fire && (cfg_reg_e'(cfg_i.index) == CFG_SAVED_THRESHOLD)) begin
      thr_q <= restore_thr(THR_W'(cfg_i.data));
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_unit_on_q     <= 1'b0;
      on_follows_engine_q <= 1'b0;
      invert_key_q        <= 1'b0;
      force_door_open_q   <= 1'b0;
      invert_door_q       <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_FORCE_UNIT_ON:     force_unit_on_q     <= cfg_i.data[0];
        CFG_ON_FOLLOWS_ENGINE: on_follows_engine_q <= cfg_i.data[0];
        CFG_INVERT_KEY:        invert_key_q        <= cfg_i.data[0];
        CFG_FORCE_DOOR_OPEN:   force_door_open_q   <= cfg_i.data[0];
        CFG_INVERT_DOOR:       invert_door_q       <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_bat_q     <= bat_pct;
      out_conn_q    <= s1_conn_q;
      out_engine_q  <= engine;
      out_changed_q <= changed;
      out_fuel_q    <= fuel_pct;
      out_unit_q    <= unit_on;
      out_door_q    <= door_open;
      out_thr_q     <= thr_new;
      out_store_q   <= s1_adapt_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.battery_percent  = out_bat_q;
  assign out_o.supply_connected = out_conn_q;
  assign out_o.engine_running   = out_engine_q;
  assign out_o.engine_changed   = out_changed_q;
  assign out_o.fuel_percent     = out_fuel_q;
  assign out_o.unit_on          = out_unit_q;
  assign out_o.door_open        = out_door_q;
  assign out_o.threshold_value  = out_thr_q;
  assign out_o.threshold_store  = out_store_q;

  // Ticks are spaced so the candidates settle before the next decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !in_i.ready)
    else $error("tick taken while decision stage busy");

  // A decided tick always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_fire |=> out_valid_q)
    else $error("decided tick lost");

  // A disconnected supply reports engine-on without change or store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_conn_q |-> out_engine_q && !out_changed_q && !out_store_q)
    else $error("disconnected tick reported wrongly");

  // A disconnected tick keeps the last connected decision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_conn_q |=> $stable(last_engine_q))
    else $error("last decision changed while disconnected");

endmodule
